// ===== rtl/tksq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tksq_pkg;

    // Store geometry
    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // List limit register
    localparam int          LIMIT_W     = 4;
    localparam int          MAX_SHOWN   = 8;
    localparam logic [3:0]  LIMIT_RESET = 4'd5;
    localparam int          CMP_W       = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;

    // Field widths
    localparam int ID_W    = 16;
    localparam int SCORE_W = 7;
    localparam int RANK_W  = 3;
    localparam int OCC_W   = 4;

    // Request modes
    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_LIST = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DROP  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ID_W-1:0]    applicant_id;
        logic [SCORE_W-1:0] score_primary;
        logic [SCORE_W-1:0] score_secondary;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    out_id;
        logic [SCORE_W-1:0] out_primary;
        logic [SCORE_W-1:0] out_secondary;
        logic [RANK_W-1:0]  rank;
        logic [OCC_W-1:0]   occupancy;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] primary;
        logic [SCORE_W-1:0] secondary;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic cap_in;
        logic do_op;
        logic list_next;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode_none;
        logic out_free;
        logic first_more;
        logic next_more;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/tksq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tksq_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tksq_pkg::sts_t sts,
    output tksq_pkg::cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Sequence: take a request, execute it, then stream any further list entries
    always_comb begin
        state_next    = state_reg;
        cmd.cap_in    = 1'b0;
        cmd.do_op     = 1'b0;
        cmd.list_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.cap_in = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.mode_none) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.do_op  = 1'b1;
                    state_next = sts.first_more ? S_LIST : S_IDLE;
                end
            end
            S_LIST: begin
                if (sts.out_free) begin
                    cmd.list_next = 1'b1;
                    if (!sts.next_more) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tksq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tksq_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire tksq_pkg::in_item_t              s_data,
    output tksq_pkg::out_item_t                  m_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    input  wire logic                            cfg_we,
    input  wire logic [tksq_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  wire tksq_pkg::cmd_t                  cmd,
    output tksq_pkg::sts_t                       sts
);

    tksq_pkg::in_item_t  in_reg;
    tksq_pkg::entry_t    entry_reg [tksq_pkg::CAPACITY];
    tksq_pkg::entry_t    entry_next [tksq_pkg::CAPACITY];
    tksq_pkg::out_item_t out_reg;
    tksq_pkg::out_item_t out_next;
    tksq_pkg::entry_t    new_entry;
    tksq_pkg::entry_t    rd_entry;

    logic [tksq_pkg::COUNT_W-1:0] count_reg;
    logic [tksq_pkg::COUNT_W-1:0] count_next;
    logic [tksq_pkg::LIMIT_W-1:0] limit_reg;
    logic [tksq_pkg::IDX_W-1:0]   idx_reg;
    logic [tksq_pkg::CMP_W-1:0]   list_n_reg;
    logic [tksq_pkg::CMP_W-1:0]   list_n_next;
    logic [tksq_pkg::CMP_W-1:0]   lim_clamped;
    logic [tksq_pkg::IDX_W-1:0]   rd_addr;
    logic [tksq_pkg::CAPACITY-1:0] ge;
    logic                          m_valid_reg;
    logic                          full;
    logic                          empty;

    assign new_entry.id        = in_reg.applicant_id;
    assign new_entry.primary   = in_reg.score_primary;
    assign new_entry.secondary = in_reg.score_secondary;

    assign full  = (count_reg == tksq_pkg::COUNT_W'(tksq_pkg::CAPACITY));
    assign empty = (count_reg == '0);

    // Compare the new key against every held entry in parallel
    always_comb begin
        for (int i = 0; i < tksq_pkg::CAPACITY; i++) begin
            ge[i] = (tksq_pkg::COUNT_W'(i) < count_reg) &&
                    ({entry_reg[i].primary, entry_reg[i].secondary} >=
                     {new_entry.primary, new_entry.secondary});
        end
    end

    // Open a gap at the insert position and shift lower-ranked entries down
    always_comb begin
        entry_next[0] = ge[0] ? entry_reg[0] : new_entry;
        for (int i = 1; i < tksq_pkg::CAPACITY; i++) begin
            if (!ge[i-1]) begin
                entry_next[i] = entry_reg[i-1];
            end else if (!ge[i]) begin
                entry_next[i] = new_entry;
            end else begin
                entry_next[i] = entry_reg[i];
            end
        end
    end

    // Single read port: list position, list head, or lowest-ranked slot
    always_comb begin
        if (cmd.list_next) begin
            rd_addr = idx_reg;
        end else if (in_reg.mode == tksq_pkg::MODE_LIST) begin
            rd_addr = '0;
        end else begin
            rd_addr = tksq_pkg::IDX_W'(count_reg - tksq_pkg::COUNT_W'(1));
        end
        rd_entry = entry_reg[rd_addr];
    end

    // Clamp the list limit and bound it by occupancy
    always_comb begin
        if (limit_reg == '0) begin
            lim_clamped = tksq_pkg::CMP_W'(1);
        end else if (tksq_pkg::CMP_W'(limit_reg) > tksq_pkg::CMP_W'(tksq_pkg::MAX_SHOWN)) begin
            lim_clamped = tksq_pkg::CMP_W'(tksq_pkg::MAX_SHOWN);
        end else begin
            lim_clamped = tksq_pkg::CMP_W'(limit_reg);
        end
        if (tksq_pkg::CMP_W'(count_reg) < lim_clamped) begin
            list_n_next = tksq_pkg::CMP_W'(count_reg);
        end else begin
            list_n_next = lim_clamped;
        end
    end

    assign sts.mode_none  = (in_reg.mode == tksq_pkg::MODE_NONE);
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign sts.first_more = (in_reg.mode == tksq_pkg::MODE_LIST) && !empty &&
                            (list_n_next > tksq_pkg::CMP_W'(1));
    assign sts.next_more  = (tksq_pkg::CMP_W'(idx_reg) + tksq_pkg::CMP_W'(1)) < list_n_reg;

    // Build the next result and the next occupancy
    always_comb begin
        out_next.status        = tksq_pkg::STATUS_OK;
        out_next.out_id        = '0;
        out_next.out_primary   = '0;
        out_next.out_secondary = '0;
        out_next.rank          = '0;
        out_next.last          = 1'b1;
        count_next             = count_reg;
        if (cmd.list_next) begin
            out_next.out_id        = rd_entry.id;
            out_next.out_primary   = rd_entry.primary;
            out_next.out_secondary = rd_entry.secondary;
            out_next.rank          = tksq_pkg::RANK_W'(idx_reg);
            out_next.last          = !sts.next_more;
        end else begin
            case (in_reg.mode)
                tksq_pkg::MODE_ENQ: begin
                    if (full) begin
                        out_next.status = tksq_pkg::STATUS_DROP;
                        if (ge[tksq_pkg::CAPACITY-1]) begin
                            out_next.out_id        = new_entry.id;
                            out_next.out_primary   = new_entry.primary;
                            out_next.out_secondary = new_entry.secondary;
                        end else begin
                            out_next.out_id        = entry_reg[tksq_pkg::CAPACITY-1].id;
                            out_next.out_primary   = entry_reg[tksq_pkg::CAPACITY-1].primary;
                            out_next.out_secondary = entry_reg[tksq_pkg::CAPACITY-1].secondary;
                        end
                    end else begin
                        count_next = count_reg + tksq_pkg::COUNT_W'(1);
                    end
                end
                tksq_pkg::MODE_DEQ: begin
                    if (empty) begin
                        out_next.status = tksq_pkg::STATUS_EMPTY;
                    end else begin
                        out_next.out_id        = rd_entry.id;
                        out_next.out_primary   = rd_entry.primary;
                        out_next.out_secondary = rd_entry.secondary;
                        count_next             = count_reg - tksq_pkg::COUNT_W'(1);
                    end
                end
                tksq_pkg::MODE_LIST: begin
                    if (empty) begin
                        out_next.status = tksq_pkg::STATUS_EMPTY;
                    end else begin
                        out_next.out_id        = rd_entry.id;
                        out_next.out_primary   = rd_entry.primary;
                        out_next.out_secondary = rd_entry.secondary;
                        out_next.last          = !sts.first_more;
                    end
                end
                default: begin
                    out_next.last = 1'b1;
                end
            endcase
        end
        out_next.occupancy = tksq_pkg::OCC_W'(count_next);
    end

    // Control state: occupancy, limit register, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            limit_reg   <= tksq_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.do_op) begin
                count_reg <= count_next;
            end
            if (cmd.do_op || cmd.list_next) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: request, store, list walk, result
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            in_reg <= s_data;
        end
        if (cmd.do_op && (in_reg.mode == tksq_pkg::MODE_ENQ)) begin
            entry_reg <= entry_next;
        end
        if (cmd.do_op) begin
            idx_reg    <= tksq_pkg::IDX_W'(1);
            list_n_reg <= list_n_next;
        end else if (cmd.list_next) begin
            idx_reg <= idx_reg + tksq_pkg::IDX_W'(1);
        end
        if (cmd.do_op || cmd.list_next) begin
            out_reg <= out_next;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/two_key_sorted_priority_queue_unit.sv =====
// A request is captured in the input register and its result in the output register.
// A new request is taken only in the idle state; list results stream one per cycle while
// the output is free, paced by the controller and the store's single read port.
// A full output register holds the controller until the result is taken.
// Reset (aresetn low, synchronous): store empty, list limit 5, output idle.
// Store contents are not cleared; only held slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module two_key_sorted_priority_queue_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire tksq_pkg::in_item_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output tksq_pkg::out_item_t               m_data,
    input  wire logic                         cfg_we,
    input  wire logic [tksq_pkg::LIMIT_W-1:0] cfg_wdata
);

    tksq_pkg::cmd_t cmd;
    tksq_pkg::sts_t sts;

    tksq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tksq_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== rtl/tksq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tksq_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire tksq_pkg::in_item_t           s_data,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire tksq_pkg::out_item_t          m_data,
    input wire logic                         cfg_we,
    input wire logic [tksq_pkg::LIMIT_W-1:0] cfg_wdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Never report more entries than the store holds
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.occupancy <= tksq_pkg::OCC_W'(tksq_pkg::CAPACITY))
        else $error("occupancy beyond capacity");

    // Empty status comes alone, with an empty store
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == tksq_pkg::STATUS_EMPTY) |->
        (m_data.occupancy == '0) && m_data.last && (m_data.out_id == '0))
        else $error("malformed empty result");

    // A drop happens only with a full store
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == tksq_pkg::STATUS_DROP) |->
        (m_data.occupancy == tksq_pkg::OCC_W'(tksq_pkg::CAPACITY)) && m_data.last)
        else $error("drop without full store");

    // No new request is taken while a list is still streaming
    a_list_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("request taken during list");

endmodule

bind two_key_sorted_priority_queue_unit tksq_checker u_tksq_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tksq_pkg::*;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_data;
    logic                cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wdata = '0;

    // Requests waiting to be offered, and results the store should produce
    in_item_t  request_q[$];
    out_item_t due_results[$];

    // Shadow of the ranking store and its list limit
    entry_t             ranked_copy[CAPACITY];
    int                 held_count = 0;
    logic [LIMIT_W-1:0] list_limit = LIMIT_RESET;

    // Traffic bookkeeping
    logic in_taken       = 1'b0;
    int   issued_count   = 0;
    int   accepted_count = 0;
    int   fail_count     = 0;
    int   send_idle      = 28;
    int   recv_idle      = 61;

    two_key_sorted_priority_queue_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Apply one request to the shadow store and queue the results it causes
    function automatic void rank_store_update(in_item_t req);
        entry_t                 fresh;
        entry_t                 gone;
        logic [2*SCORE_W-1:0]   fresh_key;
        out_item_t              r;
        int                     pos;
        int                     i;
        int                     lim;
        int                     n;
        fresh.id        = req.applicant_id;
        fresh.primary   = req.score_primary;
        fresh.secondary = req.score_secondary;
        fresh_key       = {req.score_primary, req.score_secondary};
        r               = '0;
        r.last          = 1'b1;
        case (req.mode)
            MODE_ENQ: begin
                // older entries win ties, so skip every key not below the new one
                pos = 0;
                while (pos < held_count &&
                       {ranked_copy[pos].primary, ranked_copy[pos].secondary} >= fresh_key)
                    pos++;
                if (held_count >= CAPACITY) begin
                    r.status = STATUS_DROP;
                    if (pos >= CAPACITY) begin
                        gone = fresh;
                    end else begin
                        gone = ranked_copy[CAPACITY-1];
                        for (i = CAPACITY - 1; i > pos; i--)
                            ranked_copy[i] = ranked_copy[i-1];
                        ranked_copy[pos] = fresh;
                    end
                    r.out_id        = gone.id;
                    r.out_primary   = gone.primary;
                    r.out_secondary = gone.secondary;
                end else begin
                    for (i = held_count; i > pos; i--)
                        ranked_copy[i] = ranked_copy[i-1];
                    ranked_copy[pos] = fresh;
                    held_count++;
                    r.status = STATUS_OK;
                end
                r.occupancy = OCC_W'(held_count);
                due_results.push_back(r);
            end
            MODE_DEQ: begin
                if (held_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    held_count--;
                    gone            = ranked_copy[held_count];
                    r.status        = STATUS_OK;
                    r.out_id        = gone.id;
                    r.out_primary   = gone.primary;
                    r.out_secondary = gone.secondary;
                    r.occupancy     = OCC_W'(held_count);
                end
                due_results.push_back(r);
            end
            MODE_LIST: begin
                if (held_count == 0) begin
                    r.status = STATUS_EMPTY;
                    due_results.push_back(r);
                end else begin
                    // limit zero shows one entry, anything past the maximum is capped
                    lim = list_limit;
                    if (lim == 0)
                        lim = 1;
                    if (lim > MAX_SHOWN)
                        lim = MAX_SHOWN;
                    n = (held_count < lim) ? held_count : lim;
                    for (i = 0; i < n; i++) begin
                        r.status        = STATUS_OK;
                        r.out_id        = ranked_copy[i].id;
                        r.out_primary   = ranked_copy[i].primary;
                        r.out_secondary = ranked_copy[i].secondary;
                        r.rank          = RANK_W'(i);
                        r.occupancy     = OCC_W'(held_count);
                        r.last          = (i == n - 1);
                        due_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic string show_result(out_item_t r);
        return $sformatf("status=%0d id=%h p=%0d s=%0d rank=%0d occ=%0d last=%0b",
                         r.status, r.out_id, r.out_primary, r.out_secondary,
                         r.rank, r.occupancy, r.last);
    endfunction

    // Watch both channels: check each result transfer, predict each request transfer
    always @(posedge aclk) begin
        out_item_t want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result %s", $realtime, show_result(m_data));
            end else begin
                want = due_results.pop_front();
                if (m_data.status !== want.status || m_data.out_id !== want.out_id ||
                    m_data.out_primary !== want.out_primary ||
                    m_data.out_secondary !== want.out_secondary ||
                    m_data.rank !== want.rank || m_data.occupancy !== want.occupancy ||
                    m_data.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                                 show_result(want), show_result(m_data));
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            rank_store_update(s_data);
            accepted_count++;
        end
    end

    // Offer requests on the falling edge; hold each until its transfer
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_data  <= request_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic in_item_t make_req(logic [1:0] mode, logic [ID_W-1:0] id,
                                          logic [SCORE_W-1:0] p, logic [SCORE_W-1:0] s);
        in_item_t req;
        req.mode            = mode;
        req.applicant_id    = id;
        req.score_primary   = p;
        req.score_secondary = s;
        return req;
    endfunction

    // Scores: full range, 0 to 100, or a narrow band that breeds ties
    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(2))
            0:       return SCORE_W'($urandom_range(127));
            1:       return SCORE_W'($urandom_range(100));
            default: return SCORE_W'($urandom_range(51, 48));
        endcase
    endfunction

    task automatic queue_request(in_item_t req);
        request_q.push_back(req);
        issued_count++;
    endtask

    // Random traffic weighted towards enqueue, dequeue or list, with an occasional ignored mode
    task automatic random_burst(int count, int enq_w, int deq_w, int list_w);
        int         roll;
        logic [1:0] mode;
        repeat (count) begin
            roll = $urandom_range(enq_w + deq_w + list_w + 3);
            if (roll < enq_w)
                mode = MODE_ENQ;
            else if (roll < enq_w + deq_w)
                mode = MODE_DEQ;
            else if (roll < enq_w + deq_w + list_w)
                mode = MODE_LIST;
            else
                mode = MODE_NONE;
            queue_request(make_req(mode, ID_W'($urandom()), pick_score(), pick_score()));
        end
    endtask

    // Wait until every request has transferred and every result has come
    task automatic settle_store();
        int guard = 0;
        while ((accepted_count != issued_count || due_results.size() != 0) &&
               guard < 100000) begin
            @(negedge aclk);
            guard++;
        end
        if (guard >= 100000) begin
            fail_count++;
            $display("%0t: %0d results never arrived", $realtime, due_results.size());
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        list_limit = value;
    endtask

    // Stimulus sequence
    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty store, ignored mode, extremes, ties, overflow
        queue_request(make_req(MODE_LIST, 16'h0000, 7'd0, 7'd0));
        queue_request(make_req(MODE_DEQ,  16'hFFFF, 7'd127, 7'd127));
        queue_request(make_req(MODE_NONE, 16'hFFFF, 7'd127, 7'd127));
        queue_request(make_req(MODE_ENQ,  16'h0000, 7'd0,   7'd0));
        queue_request(make_req(MODE_ENQ,  16'hFFFF, 7'd127, 7'd127));
        queue_request(make_req(MODE_ENQ,  16'h1234, 7'd50,  7'd20));
        queue_request(make_req(MODE_ENQ,  16'h1235, 7'd50,  7'd90));
        queue_request(make_req(MODE_ENQ,  16'h1236, 7'd50,  7'd20));
        queue_request(make_req(MODE_ENQ,  16'hAAAA, 7'd100, 7'd0));
        queue_request(make_req(MODE_ENQ,  16'h5555, 7'd0,   7'd100));
        queue_request(make_req(MODE_ENQ,  16'h0F0F, 7'd127, 7'd127));
        // full: a tie with the lowest entry drops the newcomer itself
        queue_request(make_req(MODE_ENQ,  16'h7777, 7'd0,   7'd0));
        queue_request(make_req(MODE_ENQ,  16'h8888, 7'd90,  7'd45));
        queue_request(make_req(MODE_LIST, 16'h0000, 7'd0,   7'd0));
        queue_request(make_req(MODE_DEQ,  16'h0000, 7'd0,   7'd0));
        queue_request(make_req(MODE_DEQ,  16'h0000, 7'd0,   7'd0));
        queue_request(make_req(MODE_LIST, 16'h0000, 7'd0,   7'd0));

        random_burst(35, 60, 15, 20);
        random_burst(25, 25, 45, 25);
        settle_store();

        write_limit(4'd1);
        random_burst(40, 55, 20, 25);
        settle_store();

        // Swap the idling between the two sides
        send_idle = 61;
        recv_idle = 28;
        write_limit(4'd8);
        random_burst(25, 65, 10, 25);
        random_burst(20, 20, 50, 25);
        settle_store();

        write_limit(4'd0);
        random_burst(35, 55, 20, 25);
        settle_store();

        // Full rate on both sides
        send_idle = 0;
        recv_idle = 0;
        write_limit(4'd15);
        random_burst(40, 60, 15, 25);
        settle_store();

        write_limit(4'd3);
        random_burst(25, 30, 40, 25);
        settle_store();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tksq_pkg.sv
rtl/tksq_ctrl.sv
rtl/tksq_dp.sv
rtl/two_key_sorted_priority_queue_unit.sv
rtl/tksq_checker.sv
tb/testbench.sv
